// File: hw/rtl/plgt_pkg.sv
// types, constants and elaboration-time table functions for the gamma transform
`timescale 1ns / 1ps

package plgt_pkg;

    localparam int PIX_W     = 8;
    localparam int GAMMA_W   = 13;
    localparam int Y_W       = 31;   // q1.30 mantissa of 2^f
    localparam int Q_FRAC    = 30;
    localparam int HEAD_BITS = 8;    // leading fraction bits served by a table
    localparam int SHIFT_W   = 3;
    localparam int TAB_DEPTH = 256;

    localparam logic [GAMMA_W-1:0] GAMMA_MIN   = 13'd3;
    localparam logic [GAMMA_W-1:0] GAMMA_MAX   = 13'd6400;
    localparam logic [GAMMA_W-1:0] GAMMA_RESET = 13'd256;
    localparam logic [PIX_W-1:0]   PIX_SAT     = 8'hFF;

    // control that rides along with each word through the exp2 pipe
    typedef struct packed {
        logic               zero;
        logic               sat;
        logic [SHIFT_W-1:0] shift;
    } t_ctl;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        v    = v_in;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 64'd0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // 2^(2^-idx) in q1.30, idx from 1
    function automatic logic [Y_W-1:0] root_q30(input int idx);
        logic [63:0] r;
        r = isqrt64(64'd1 << 61);
        for (int n = 1; n < idx; n++) r = isqrt64(r << 30);
        return r[Y_W-1:0];
    endfunction

    // log2(x) in q3.fb, bit-serial squaring of the mantissa
    function automatic logic [31:0] log2_q(input int x, input int fb);
        int          n;
        logic [63:0] m;
        logic [31:0] lg;
        n = 0;
        while (n < 7 && (x >> (n + 1)) != 0) n++;
        m  = 64'(x) << (30 - n);
        lg = 32'(n) << fb;
        for (int i = 0; i < fb; i++) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
                m  = m >> 1;
                lg = lg | (32'd1 << (fb - 1 - i));
            end
        end
        return lg;
    endfunction

    // partial 2^f after the leading HEAD_BITS fraction bits, msb first
    function automatic logic [Y_W-1:0] exp2_head(input int idx);
        logic [63:0] y;
        logic [63:0] r;
        y = 64'd1 << 30;
        r = isqrt64(64'd1 << 61);
        for (int i = 1; i <= HEAD_BITS; i++) begin
            if (((idx >> (HEAD_BITS - i)) & 1) != 0) y = (y * r) >> 30;
            r = isqrt64(r << 30);
        end
        return y[Y_W-1:0];
    endfunction

endpackage

// File: hw/rtl/plgt_in_if.sv
// input channel: one sample word
`timescale 1ns / 1ps

interface plgt_in_if;
    logic                        valid;
    logic                        ready;
    logic [plgt_pkg::PIX_W-1:0]  pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

// File: hw/rtl/plgt_out_if.sv
// output channel: one result word with saturation flag
`timescale 1ns / 1ps

interface plgt_out_if;
    logic                        valid;
    logic                        ready;
    logic [plgt_pkg::PIX_W-1:0]  pixel_out;
    logic                        clipped;

    modport source (output valid, output pixel_out, output clipped, input ready);
    modport sink   (input valid, input pixel_out, input clipped, output ready);
endinterface

// File: hw/rtl/plgt_exp_stage.sv
// one exp2 pipeline stage: conditional multiply by a fixed root of two
`timescale 1ns / 1ps

module plgt_exp_stage #(
    parameter int                         TAIL_W = 16,
    parameter int                         BIT    = 15,
    parameter logic [plgt_pkg::Y_W-1:0]   ROOT   = 31'h4000_0000
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [plgt_pkg::Y_W-1:0]    i_y,
    input  logic [TAIL_W-1:0]           i_tail,
    input  plgt_pkg::t_ctl              i_ctl,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [plgt_pkg::Y_W-1:0]    o_y,
    output logic [TAIL_W-1:0]           o_tail,
    output plgt_pkg::t_ctl              o_ctl
);

    localparam int P_W = 2 * plgt_pkg::Y_W;

    logic                       r_valid;
    logic [plgt_pkg::Y_W-1:0]   r_y;
    logic [TAIL_W-1:0]          r_tail;
    plgt_pkg::t_ctl             r_ctl;
    logic [plgt_pkg::Y_W-1:0]   n_y;
    logic [P_W-1:0]             w_prod;
    logic                       w_ld;

    assign w_ld    = !r_valid || i_ready;
    assign o_ready = w_ld;
    assign w_prod  = P_W'(i_y) * P_W'(ROOT);

    // truncating q1.30 multiply, taken only when this fraction bit is set
    always_comb begin
        n_y = i_tail[BIT]
            ? w_prod[plgt_pkg::Q_FRAC+plgt_pkg::Y_W-1:plgt_pkg::Q_FRAC]
            : i_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ld) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld) begin
            r_y    <= n_y;
            r_tail <= i_tail;
            r_ctl  <= i_ctl;
        end
    end

    assign o_valid = r_valid;
    assign o_y     = r_y;
    assign o_tail  = r_tail;
    assign o_ctl   = r_ctl;

endmodule

// File: hw/rtl/power_law_gamma_transform_unit.sv
// top level of the power-law gamma transform pipeline
`timescale 1ns / 1ps

// Power-law transform of 8-bit samples: each input word x gives floor(x^g), where g is the
// exponent register in unsigned q5.8 (reset 256 = 1.0), clamped to 3..6400 when written.
// A sample of 0 gives 0; results past 255 saturate to 255 with clipped set. The power is
// formed as exp2(log2(x) * g): a 256-entry log2 table, one (LOG_FRAC_BITS + 3) x 13 multiply,
// a 256-entry table for the first eight fraction bits of the exponent, then one pipeline
// stage per remaining fraction bit, each a truncating q1.30 multiply by a fixed root of two.
// Results next to integer boundaries may be one low. Throughput is one word per clock while
// the output is not stalled. A word passes through log lookup, multiply, head lookup,
// LOG_FRAC_BITS root stages and the output register. Every stage has its own valid bit and
// loads whenever it is empty or its successor loads, so bubbles collapse and a stalled output
// keeps accepting words until the pipe is full. The exponent register may only be written
// while no word is in flight.

module power_law_gamma_transform_unit #(
    parameter int LOG_FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [plgt_pkg::GAMMA_W-1:0]    i_cfg_wr_data,
    plgt_in_if.sink                         i_in,
    plgt_out_if.source                      o_out
);

    localparam int LF    = LOG_FRAC_BITS;
    localparam int LOG_W = LF + 3;                     // q3.LF log2
    localparam int E_W   = LOG_W + plgt_pkg::GAMMA_W;  // exact product
    localparam int FB    = LF + 8;                     // fraction bits of the product
    localparam int Y_W   = plgt_pkg::Y_W;
    localparam int SH_W  = Y_W + 7;                    // y shifted left by up to seven

    // constant tables
    logic [LOG_W-1:0] w_log_tab  [plgt_pkg::TAB_DEPTH];
    logic [Y_W-1:0]   w_head_tab [plgt_pkg::TAB_DEPTH];

    for (genvar gi = 0; gi < plgt_pkg::TAB_DEPTH; gi++) begin : g_tab
        localparam logic [LOG_W-1:0] LV = LOG_W'(plgt_pkg::log2_q(gi, LF));
        localparam logic [Y_W-1:0]   HV = plgt_pkg::exp2_head(gi);
        assign w_log_tab[gi]  = LV;
        assign w_head_tab[gi] = HV;
    end

    // exponent register, clamped on write
    logic [plgt_pkg::GAMMA_W-1:0] r_gamma;
    logic [plgt_pkg::GAMMA_W-1:0] n_gamma;

    always_comb begin
        n_gamma = i_cfg_wr_data;
        if (i_cfg_wr_data < plgt_pkg::GAMMA_MIN) n_gamma = plgt_pkg::GAMMA_MIN;
        if (i_cfg_wr_data > plgt_pkg::GAMMA_MAX) n_gamma = plgt_pkg::GAMMA_MAX;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma <= plgt_pkg::GAMMA_RESET;
        end else if (i_cfg_wr_en) begin
            r_gamma <= n_gamma;
        end
    end

    // pipeline handshake chain
    logic w_a_ld, w_b_ld, w_c_ld, w_out_ld;
    logic w_rdy [LF+1];

    // stage a: log2 lookup
    logic             r_a_valid;
    logic [LOG_W-1:0] r_a_log;
    logic             r_a_zero;

    assign w_a_ld     = !r_a_valid || w_b_ld;
    assign i_in.ready = w_a_ld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_a_ld) begin
            r_a_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_ld) begin
            r_a_log  <= w_log_tab[i_in.pixel_in];
            r_a_zero <= (i_in.pixel_in == '0);
        end
    end

    // stage b: exact product log2(x) * g
    logic           r_b_valid;
    logic [E_W-1:0] r_b_e;
    logic           r_b_zero;

    assign w_b_ld = !r_b_valid || w_c_ld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_b_ld) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_ld) begin
            r_b_e    <= E_W'(r_a_log) * E_W'(r_gamma);
            r_b_zero <= r_a_zero;
        end
    end

    // stage c: split integer and fraction, head table for the top fraction bits
    logic             r_c_valid;
    logic [Y_W-1:0]   r_c_y;
    logic [LF-1:0]    r_c_tail;
    plgt_pkg::t_ctl   r_c_ctl;
    plgt_pkg::t_ctl   n_c_ctl;

    assign w_c_ld = !r_c_valid || w_rdy[0];

    always_comb begin
        n_c_ctl.zero  = r_b_zero;
        // integer part of eight or more overflows any nonzero sample
        n_c_ctl.sat   = |r_b_e[E_W-1:FB+plgt_pkg::SHIFT_W];
        n_c_ctl.shift = r_b_e[FB+plgt_pkg::SHIFT_W-1:FB];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_c_ld) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_c_ld) begin
            r_c_y    <= w_head_tab[r_b_e[FB-1:LF]];
            r_c_tail <= r_b_e[LF-1:0];
            r_c_ctl  <= n_c_ctl;
        end
    end

    // root-multiply stages, one per remaining fraction bit, msb first
    logic           w_v    [LF+1];
    logic [Y_W-1:0] w_y    [LF+1];
    logic [LF-1:0]  w_tail [LF+1];
    plgt_pkg::t_ctl w_ctl  [LF+1];

    assign w_v[0]    = r_c_valid;
    assign w_y[0]    = r_c_y;
    assign w_tail[0] = r_c_tail;
    assign w_ctl[0]  = r_c_ctl;
    assign w_rdy[LF] = w_out_ld;

    for (genvar gj = 0; gj < LF; gj++) begin : g_exp
        localparam logic [Y_W-1:0] RT = plgt_pkg::root_q30(plgt_pkg::HEAD_BITS + 1 + gj);
        plgt_exp_stage #(
            .TAIL_W (LF),
            .BIT    (LF - 1 - gj),
            .ROOT   (RT)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[gj]),
            .o_ready (w_rdy[gj]),
            .i_y     (w_y[gj]),
            .i_tail  (w_tail[gj]),
            .i_ctl   (w_ctl[gj]),
            .o_valid (w_v[gj+1]),
            .i_ready (w_rdy[gj+1]),
            .o_y     (w_y[gj+1]),
            .o_tail  (w_tail[gj+1]),
            .o_ctl   (w_ctl[gj+1])
        );
    end

    // output stage: scale by 2^k, truncate, saturate; a zero sample gives 0
    logic                         r_out_valid;
    logic [plgt_pkg::PIX_W-1:0]   r_out_pixel;
    logic                         r_out_clip;
    logic [SH_W-1:0]              w_shifted;
    logic [plgt_pkg::PIX_W-1:0]   n_out_pixel;
    logic                         n_out_clip;
    plgt_pkg::t_ctl               w_last_ctl;

    assign w_out_ld   = !r_out_valid || o_out.ready;
    assign w_last_ctl = w_ctl[LF];
    // y is below 2.0, so with a shift of at most seven the result stays below 256
    assign w_shifted  = SH_W'(w_y[LF]) << w_last_ctl.shift;

    always_comb begin
        n_out_pixel = w_shifted[SH_W-1:plgt_pkg::Q_FRAC];
        n_out_clip  = 1'b0;
        if (w_last_ctl.zero) begin
            n_out_pixel = '0;
        end else if (w_last_ctl.sat) begin
            n_out_pixel = plgt_pkg::PIX_SAT;
            n_out_clip  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ld) begin
            r_out_valid <= w_v[LF];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ld) begin
            r_out_pixel <= n_out_pixel;
            r_out_clip  <= n_out_clip;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.pixel_out = r_out_pixel;
    assign o_out.clipped   = r_out_clip;

    // a saturated word always carries the full-scale code
    a_clip_full_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.clipped |-> o_out.pixel_out == plgt_pkg::PIX_SAT)
        else $error("clipped word without full-scale value");

    // an accepted word lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_a_valid)
        else $error("accepted word lost at pipe entry");

    // exponent register always holds a clamped value after a write
    a_gamma_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |=> (r_gamma >= plgt_pkg::GAMMA_MIN) && (r_gamma <= plgt_pkg::GAMMA_MAX))
        else $error("exponent register outside clamp range");

    // a held head stage keeps its word while the root pipe is blocked
    a_head_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid && !w_rdy[0] |=> r_c_valid && $stable(r_c_y) && $stable(r_c_tail))
        else $error("head stage word changed while blocked");

endmodule
